>>> src/rddr_pkg.sv
package rddr_pkg;

  localparam int TICK_BITS     = 11;
  localparam int RAMP_TICKS    = 90;
  localparam int LEVEL_BITS    = 16;
  localparam int RAMP_IDX_BITS = $clog2(RAMP_TICKS);
  localparam int CFG_IDX_BITS  = 2;

  typedef logic [TICK_BITS-1:0]  tick_t;
  typedef logic [LEVEL_BITS-1:0] level_t;

  localparam level_t FULL_LEVEL = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DAWN       = 2'd0,
    CFG_LIGHTS_ON  = 2'd1,
    CFG_LIGHTS_OFF = 2'd2,
    CFG_DUSK       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    tick_t dawn;
    tick_t lights_on;
    tick_t lights_off;
    tick_t dusk;
  } cfg_t;

  typedef struct packed {
    logic   main_lights;
    logic   driver_enable;
    level_t red;
    level_t green;
    level_t blue;
  } result_t;

  typedef level_t ramp_lut_t [RAMP_TICKS];

  localparam longint FullLevel = longint'(2) ** LEVEL_BITS - 1;
  localparam longint RedDen    = RAMP_TICKS;
  localparam longint GreenDen  = 4 * RAMP_TICKS;
  localparam longint BlueDen   = 3 * RAMP_TICKS;

  function automatic level_t to_level(longint q);
    level_t lvl;
    if (q <= 0) begin
      lvl = '0;
    end else if (q > FullLevel) begin
      lvl = FULL_LEVEL;
    end else begin
      lvl = LEVEL_BITS'(q);
    end
    return lvl;
  endfunction

  // Each table holds the level for a ramp position measured from the dark end.
  function automatic ramp_lut_t build_red_lut();
    ramp_lut_t lut;
    for (int i = 0; i < RAMP_TICKS; i++) begin
      lut[i] = to_level((longint'(i) * FullLevel + RedDen / 2) / RedDen);
    end
    return lut;
  endfunction

  function automatic ramp_lut_t build_green_lut();
    ramp_lut_t lut;
    longint    num;
    for (int i = 0; i < RAMP_TICKS; i++) begin
      num    = 5 * longint'(i) - RedDen;
      lut[i] = (num <= 0) ? '0 : to_level((num * FullLevel + GreenDen / 2) / GreenDen);
    end
    return lut;
  endfunction

  function automatic ramp_lut_t build_blue_lut();
    ramp_lut_t lut;
    longint    num;
    for (int i = 0; i < RAMP_TICKS; i++) begin
      num    = 5 * longint'(i) - 2 * RedDen;
      lut[i] = (num <= 0) ? '0 : to_level((num * FullLevel + BlueDen / 2) / BlueDen);
    end
    return lut;
  endfunction

  localparam ramp_lut_t RED_LUT   = build_red_lut();
  localparam ramp_lut_t GREEN_LUT = build_green_lut();
  localparam ramp_lut_t BLUE_LUT  = build_blue_lut();

endpackage

>>> src/rddr_cfg_regs.sv
module rddr_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rddr_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  rddr_pkg::tick_t                  cfg_wdata_i,
  output rddr_pkg::cfg_t                   cfg_o
);

  rddr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rddr_pkg::cfg_idx_e'(cfg_index_i))
        rddr_pkg::CFG_DAWN:       cfg_q.dawn       <= cfg_wdata_i;
        rddr_pkg::CFG_LIGHTS_ON:  cfg_q.lights_on  <= cfg_wdata_i;
        rddr_pkg::CFG_LIGHTS_OFF: cfg_q.lights_off <= cfg_wdata_i;
        rddr_pkg::CFG_DUSK:       cfg_q.dusk       <= cfg_wdata_i;
        default:                  cfg_q            <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/rddr_level_calc.sv
module rddr_level_calc (
  input  rddr_pkg::tick_t   minute_i,
  input  rddr_pkg::cfg_t    cfg_i,
  output rddr_pkg::result_t result_o
);

  logic                               dawn_hit;
  logic                               dusk_hit;
  logic                               ramp_full;
  rddr_pkg::tick_t                    ramp_pos;
  logic [rddr_pkg::RAMP_IDX_BITS-1:0] lut_idx;

  assign dawn_hit = (minute_i >= cfg_i.dawn) && (minute_i < cfg_i.lights_on);
  assign dusk_hit = (minute_i > cfg_i.lights_off) && (minute_i <= cfg_i.dusk);

  // Distance from the dark end of the ramp: after dawn start, or before dusk end.
  assign ramp_pos  = dawn_hit ? (minute_i - cfg_i.dawn) : (cfg_i.dusk - minute_i);
  assign ramp_full = ramp_pos >= rddr_pkg::TICK_BITS'(rddr_pkg::RAMP_TICKS);
  assign lut_idx   = ramp_pos[rddr_pkg::RAMP_IDX_BITS-1:0];

  always_comb begin
    result_o.main_lights   = (minute_i >= cfg_i.lights_on) && (minute_i <= cfg_i.lights_off);
    result_o.driver_enable = dawn_hit || dusk_hit || (minute_i >= cfg_i.lights_off);
    if (!(dawn_hit || dusk_hit)) begin
      result_o.red   = '0;
      result_o.green = '0;
      result_o.blue  = '0;
    end else if (ramp_full) begin
      result_o.red   = rddr_pkg::FULL_LEVEL;
      result_o.green = rddr_pkg::FULL_LEVEL;
      result_o.blue  = rddr_pkg::FULL_LEVEL;
    end else begin
      result_o.red   = rddr_pkg::RED_LUT[lut_idx];
      result_o.green = rddr_pkg::GREEN_LUT[lut_idx];
      result_o.blue  = rddr_pkg::BLUE_LUT[lut_idx];
    end
  end

endmodule

>>> src/rgb_dawn_dusk_ramp_core.sv
// Dawn and dusk light controller. Each input beat carries one minute-of-day
// tick; each output beat carries the main-light switch, the LED driver enable
// and the red, green and blue levels for that tick, in input order.
// Both channels use valid and stall: a beat moves on a rising edge where valid
// is high and stall is low. The four window registers are written through the
// cfg_we_i / cfg_index_i / cfg_wdata_i port; the user must write them only
// while no beat is in flight, as the block itself does not enforce this. Each
// beat passes through the input register and then the result register, with
// the window compares and the ramp table lookup in between. Throughput is one
// beat per cycle while the receiver does not stall. When the receiver stalls,
// the result register holds its beat and the input register can still take
// one more; after that in_stall_o rises until the result register empties.
// Reset clears all window registers to zero and empties both pipeline stages;
// no clearing pass is needed, so the block takes beats right after reset.
module rgb_dawn_dusk_ramp_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rddr_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [rddr_pkg::TICK_BITS-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rddr_pkg::TICK_BITS-1:0]    minute_of_day_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              main_lights_o,
  output logic                              driver_enable_o,
  output logic [rddr_pkg::LEVEL_BITS-1:0]   red_level_o,
  output logic [rddr_pkg::LEVEL_BITS-1:0]   green_level_o,
  output logic [rddr_pkg::LEVEL_BITS-1:0]   blue_level_o
);

  rddr_pkg::cfg_t    cfg;
  rddr_pkg::result_t calc;
  rddr_pkg::result_t res_q;
  rddr_pkg::tick_t   minute_q;
  logic              in_vld_q;
  logic              out_vld_q;
  logic              res_adv;
  logic              in_adv;

  rddr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rddr_level_calc u_level_calc (
    .minute_i (minute_q),
    .cfg_i    (cfg),
    .result_o (calc)
  );

  assign res_adv    = !out_vld_q || !out_stall_i;
  assign in_adv     = !in_vld_q || res_adv;
  assign in_stall_o = !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_q <= in_valid_i;
      end
      if (res_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      minute_q <= minute_of_day_i;
    end
    if (res_adv && in_vld_q) begin
      res_q <= calc;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign main_lights_o   = res_q.main_lights;
  assign driver_enable_o = res_q.driver_enable;
  assign red_level_o     = res_q.red;
  assign green_level_o   = res_q.green;
  assign blue_level_o    = res_q.blue;

endmodule

>>> src/rddr_port_checker.sv
module rddr_port_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            main_lights_o,
  input logic                            driver_enable_o,
  input logic [rddr_pkg::LEVEL_BITS-1:0] red_level_o,
  input logic [rddr_pkg::LEVEL_BITS-1:0] green_level_o,
  input logic [rddr_pkg::LEVEL_BITS-1:0] blue_level_o
);

  // A stalled output beat stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_level_o)
      && $stable(green_level_o) && $stable(blue_level_o)
      && $stable(driver_enable_o) && $stable(main_lights_o))
    else $error("stalled output beat changed");

  // An accepted beat reaches the output if the receiver does not stall while the beat sits in the input register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted beat did not reach the output in two cycles");

  // The input side never stalls while the output register is empty.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output stage");

  // Outside the twilight windows and the handover the levels are dark.
  a_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !driver_enable_o |-> red_level_o == '0 && green_level_o == '0
      && blue_level_o == '0)
    else $error("nonzero level with the driver off");

  // Red leads green and green leads blue on every ramp.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> red_level_o >= green_level_o && green_level_o >= blue_level_o)
    else $error("color levels out of order");

endmodule

bind rgb_dawn_dusk_ramp_core rddr_port_checker u_port_checker (.*);
